FILE: sv/gamepad_poll_sequencer_top_defines.svh
// Assertion macros for the gamepad poll sequencer.
`ifndef GAMEPAD_POLL_SEQUENCER_TOP_DEFINES_SVH
`define GAMEPAD_POLL_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define GPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define GPS_ASSERT_IMP(label, clk, rst, ante, cons)
`define GPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/gps_pkg.sv
`timescale 1ns / 1ps
package gps_pkg;

   localparam int STORE_DEPTH_DEF = 32;
   localparam int POS_W = 6;
   localparam int PC_W  = 4;

   // operation codes
   localparam logic [1:0] OP_EXCHANGE = 2'd0;
   localparam logic [1:0] OP_HOST     = 2'd1;
   localparam logic [1:0] OP_FRAME    = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CMD     = 2'd0;
   localparam logic [1:0] KIND_HOST    = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [7:0] CMD_START    = 8'h01;
   localparam logic [7:0] CMD_POLL     = 8'h42;
   localparam logic [7:0] HOST_DUMP    = 8'h7A;
   localparam logic [7:0] MODE_DIGITAL = 8'h41;
   localparam logic [7:0] MODE_ANALOG  = 8'h73;
   localparam logic [7:0] MODE_FULL    = 8'h79;

   // microprogram addresses
   localparam logic [PC_W-1:0] ST_FETCH    = 4'd0;
   localparam logic [PC_W-1:0] ST_DISPATCH = 4'd1;
   localparam logic [PC_W-1:0] ST_OPEN     = 4'd2;
   localparam logic [PC_W-1:0] ST_SEND     = 4'd3;
   localparam logic [PC_W-1:0] ST_EXCH     = 4'd4;
   localparam logic [PC_W-1:0] ST_TEST     = 4'd5;
   localparam logic [PC_W-1:0] ST_CLOSE    = 4'd6;
   localparam logic [PC_W-1:0] ST_RELEASE  = 4'd7;
   localparam logic [PC_W-1:0] ST_DUMP     = 4'd8;
   localparam logic [PC_W-1:0] ST_READ     = 4'd9;
   localparam logic [PC_W-1:0] ST_OUT      = 4'd10;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] reply_byte;
      logic [7:0] host_byte;
      logic       mode_select_level;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       connected;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_OPEN,
      ACT_EXCHANGE,
      ACT_CLOSE,
      ACT_DUMP_INIT,
      ACT_READ,
      ACT_EMIT_CMD,
      ACT_EMIT_REL,
      ACT_EMIT_DATA
   } act_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_DISPATCH,
      C_MORE_BYTES,
      C_DUMP_DONE
   } cond_type;

   typedef struct packed {
      act_type         act;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         ST_FETCH:    w = '{ACT_LATCH,     C_NO_REQ,     ST_FETCH};
         ST_DISPATCH: w = '{ACT_NONE,      C_DISPATCH,   ST_FETCH};
         ST_OPEN:     w = '{ACT_OPEN,      C_NEXT,       ST_FETCH};
         ST_SEND:     w = '{ACT_EMIT_CMD,  C_ALWAYS,     ST_FETCH};
         ST_EXCH:     w = '{ACT_EXCHANGE,  C_NEXT,       ST_FETCH};
         ST_TEST:     w = '{ACT_NONE,      C_MORE_BYTES, ST_SEND};
         ST_CLOSE:    w = '{ACT_CLOSE,     C_NEXT,       ST_FETCH};
         ST_RELEASE:  w = '{ACT_EMIT_REL,  C_ALWAYS,     ST_FETCH};
         ST_DUMP:     w = '{ACT_DUMP_INIT, C_NEXT,       ST_FETCH};
         ST_READ:     w = '{ACT_READ,      C_DUMP_DONE,  ST_FETCH};
         ST_OUT:      w = '{ACT_EMIT_DATA, C_ALWAYS,     ST_READ};
         default:     w = '{ACT_NONE,      C_ALWAYS,     ST_FETCH};
      endcase
      return w;
   endfunction

   function automatic logic mode_valid(input logic [7:0] m);
      return (m == MODE_DIGITAL) || (m == MODE_ANALOG) || (m == MODE_FULL);
   endfunction

   // trailing zero bytes after the six-byte head of each config packet
   function automatic logic [3:0] cfg_tail(input logic [2:0] pkt);
      logic [3:0] t;
      unique case (pkt)
         3'd1, 3'd2, 3'd3: t = 4'd3;
         3'd4:             t = 4'd15;
         default:          t = 4'd0;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] cfg_byte(input logic [2:0] pkt, input logic [1:0] col);
      logic [31:0] row;
      unique case (pkt)
         3'd1:    row = 32'h44_01_03_00;
         3'd2:    row = 32'h4F_FF_FF_03;
         3'd3:    row = 32'h43_00_5A_00;
         3'd4:    row = 32'h42_00_00_00;
         default: row = 32'h43_01_00_00;
      endcase
      return row[8*(3-col) +: 8];
   endfunction

   function automatic logic [7:0] command_at(input logic polling, input logic [2:0] pkt,
                                             input logic [POS_W-1:0] pos);
      logic [7:0] b;
      if (pos == '0) begin
         b = CMD_START;
      end else if (polling) begin
         b = (pos == POS_W'(1)) ? CMD_POLL : 8'h00;
      end else begin
         unique case (pos)
            POS_W'(1): b = cfg_byte(pkt, 2'd0);
            POS_W'(3): b = cfg_byte(pkt, 2'd1);
            POS_W'(4): b = cfg_byte(pkt, 2'd2);
            POS_W'(5): b = cfg_byte(pkt, 2'd3);
            default:   b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

FILE: sv/gamepad_poll_sequencer_top.sv
`timescale 1ns / 1ps
`include "gamepad_poll_sequencer_top_defines.svh"
// Host-side sequencer for a serial gamepad link, run by an eleven-step microprogram held in a
// constant table. One word is taken at a time: a frame start opens the frame and emits the start
// command, a finished exchange emits the next command byte or closes the frame and emits a release,
// an ignored word emits nothing, and a dump takes one store read and one output step per byte.
// A step that emits a result waits while the result register is full and stalled.
// Results for one word carry last on the final one.
module gamepad_poll_sequencer_top #(
   parameter int STORE_DEPTH = gps_pkg::STORE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gps_pkg::rsp_type rsp_data
);
   import gps_pkg::*;

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [PC_W-1:0]  pc_ff, pc_in;
   req_type          req_q_ff;
   logic             polling_ff, polling_in;
   logic [2:0]       pkt_ff, pkt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             in_frame_ff, in_frame_in;
   logic [7:0]       mode_ff, mode_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [7:0]             mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] wvalid_ff;
   logic [7:0]             rd_data_ff;
   logic                   rd_valid_ff;

   uword_type        uw;
   logic             hold;
   logic             accept;
   logic [POS_W-1:0] count;
   logic [POS_W-1:0] frame_len;
   logic [POS_W-1:0] rel;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             conn;
   logic [PC_W-1:0]  dispatch;
   logic             keep;
   logic             poll_open;
   logic [2:0]       pkt_open;

   assign uw        = ucode(pc_ff);
   assign accept    = req_valid && (pc_ff == ST_FETCH);
   assign req_stall = (pc_ff != ST_FETCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hold = ((uw.act == ACT_EMIT_CMD) || (uw.act == ACT_EMIT_REL) ||
                  (uw.act == ACT_EMIT_DATA)) && rsp_valid_ff && rsp_stall;

   // count = min(2 * low nibble of mode, depth)
   always_comb begin
      count = {1'b0, mode_ff[3:0], 1'b0};
      if (count > POS_W'(STORE_DEPTH)) begin
         count = POS_W'(STORE_DEPTH);
      end
   end

   assign frame_len = polling_ff ? (POS_W'(3) + count)
                                 : (POS_W'(6) + {2'b00, cfg_tail(pkt_ff)});
   assign conn      = polling_ff && mode_valid(mode_ff);

   assign rel     = pos_ff - POS_W'(3);
   assign wr_en   = (uw.act == ACT_EXCHANGE) && polling_ff && (pos_ff >= POS_W'(3)) &&
                    (rel < count);
   assign wr_addr = rel[AW-1:0];
   assign rd_en   = (uw.act == ACT_READ);
   assign rd_addr = idx_ff[AW-1:0];

   always_comb begin
      unique case (req_q_ff.operation)
         OP_FRAME:    dispatch = in_frame_ff ? ST_FETCH : ST_OPEN;
         OP_EXCHANGE: dispatch = in_frame_ff ? ST_EXCH : ST_FETCH;
         OP_HOST:     dispatch = (req_q_ff.host_byte == HOST_DUMP) ? ST_DUMP : ST_FETCH;
         default:     dispatch = ST_FETCH;
      endcase
   end

   // mode check and full-analog skip at frame open
   always_comb begin
      keep = (((mode_ff == MODE_DIGITAL) || (mode_ff == MODE_ANALOG)) &&
              req_q_ff.mode_select_level) ||
             ((mode_ff == MODE_FULL) && !req_q_ff.mode_select_level);
      poll_open = polling_ff && keep;
      pkt_open  = (polling_ff && !keep) ? 3'd0 : pkt_ff;
      if (!poll_open && (pkt_open == 3'd2) && req_q_ff.mode_select_level) begin
         pkt_open = 3'd3;
      end
   end

   always_comb begin
      pc_in        = pc_ff;
      polling_in   = polling_ff;
      pkt_in       = pkt_ff;
      pos_in       = pos_ff;
      in_frame_in  = in_frame_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (!hold) begin
         unique case (uw.act)
            ACT_NONE, ACT_LATCH, ACT_READ: begin
            end
            ACT_OPEN: begin
               polling_in  = poll_open;
               pkt_in      = pkt_open;
               if (polling_ff && !keep) begin
                  mode_in = 8'h00;
               end
               in_frame_in = 1'b1;
               pos_in      = '0;
            end
            ACT_EXCHANGE: begin
               if (pos_ff == POS_W'(1)) begin
                  mode_in = req_q_ff.reply_byte;
               end
               pos_in = pos_ff + POS_W'(1);
            end
            ACT_CLOSE: begin
               pos_in      = '0;
               in_frame_in = 1'b0;
               if (!polling_ff) begin
                  if (pkt_ff >= 3'd4) begin
                     pkt_in = 3'd0;
                     if (mode_valid(mode_ff)) begin
                        polling_in = 1'b1;
                     end
                  end else begin
                     pkt_in = pkt_ff + 3'd1;
                  end
               end
            end
            ACT_DUMP_INIT: begin
               idx_in = '0;
            end
            ACT_EMIT_CMD: begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_CMD, command_at(polling_ff, pkt_ff, pos_ff), conn, 1'b1};
            end
            ACT_EMIT_REL: begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_RELEASE, 8'h00, conn, 1'b1};
            end
            ACT_EMIT_DATA: begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_HOST, rd_valid_ff ? rd_data_ff : 8'h00, conn,
                                (idx_ff + POS_W'(1)) == count};
               idx_in       = idx_ff + POS_W'(1);
            end
            default: begin
            end
         endcase

         unique case (uw.cond)
            C_NEXT:       pc_in = pc_ff + PC_W'(1);
            C_ALWAYS:     pc_in = uw.target;
            C_NO_REQ:     pc_in = req_valid ? (pc_ff + PC_W'(1)) : uw.target;
            C_DISPATCH:   pc_in = dispatch;
            C_MORE_BYTES: pc_in = (pos_ff < frame_len) ? uw.target : (pc_ff + PC_W'(1));
            C_DUMP_DONE:  pc_in = (idx_ff >= count) ? uw.target : (pc_ff + PC_W'(1));
            default:      pc_in = ST_FETCH;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_FETCH;
         polling_ff   <= 1'b0;
         pkt_ff       <= 3'd0;
         pos_ff       <= '0;
         in_frame_ff  <= 1'b0;
         mode_ff      <= 8'h00;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         polling_ff   <= polling_in;
         pkt_ff       <= pkt_in;
         pos_ff       <= pos_in;
         in_frame_ff  <= in_frame_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_q_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // sample store; entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_q_ff.reply_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wvalid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= wvalid_ff[rd_addr];
         end
      end
   end

   `GPS_ASSERT_IMP(a_poll_pkt_zero, clock, reset, polling_ff, pkt_ff == 3'd0)
   `GPS_ASSERT_IMP(a_pos_in_frame, clock, reset, in_frame_ff && (pc_ff == ST_FETCH), pos_ff < frame_len)
   `GPS_ASSERT_IMP(a_dump_idx, clock, reset, pc_ff == ST_OUT, idx_ff < count)
   `GPS_ASSERT_NEXT(a_read_to_out, clock, reset, (pc_ff == ST_READ) && (idx_ff < count), pc_ff == ST_OUT)

endmodule
